// ===== design/idsa_pkg.sv =====
// Shared command and status codes for the ID slot allocator.
`timescale 1ns / 1ps
package idsa_pkg;

   localparam logic [1:0] CMD_NEXT_FIT = 2'd0;
   localparam logic [1:0] CMD_TOP      = 2'd1;
   localparam logic [1:0] CMD_RELEASE  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_BAD_ID    = 2'd2;

   localparam int ID_WIDTH     = 7;
   localparam int STATUS_WIDTH = 2;
   localparam int CMD_WIDTH    = 2;
   localparam int DATA_WIDTH   = 32;
   localparam int ADDR_WIDTH   = 2;

   localparam logic [ADDR_WIDTH-1:0] ADDR_ACTIVE_COUNT = 2'd0;
   localparam logic [ID_WIDTH-1:0]   ACTIVE_COUNT_RESET = 7'd64;

endpackage

// ===== design/id_slot_allocator.sv =====
// ID slot allocator: next-fit / top-down bitmap ID allocation with a scan sequencer.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/ready     req_cmd, req_release_id
//   rsp       out        rsp_valid/ready     rsp_granted_id, rsp_status
//   csr       in/out     APB psel/penable    paddr, pwdata, prdata (active_count)
//
// Acquire: scans at most the active count of slots, capped at MAX_IDS and 127, one map
// read per cycle through the registered port of the used-bit memory.
// Release and the unused command go from idle straight to the response state.
// After reset a clearing pass writes every map entry before
// the first transaction is taken. A result waits in the output register; the
// block takes the next transaction while it waits and stalls only if a second
// result is ready before the first has been taken.
`timescale 1ns / 1ps
module id_slot_allocator #(
   parameter int MAX_IDS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [idsa_pkg::CMD_WIDTH-1:0]         req_cmd,
   input  logic [idsa_pkg::ID_WIDTH-1:0]          req_release_id,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [idsa_pkg::ID_WIDTH-1:0]          rsp_granted_id,
   output logic [idsa_pkg::STATUS_WIDTH-1:0]      rsp_status,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [idsa_pkg::ADDR_WIDTH-1:0]        paddr,
   input  logic [idsa_pkg::DATA_WIDTH-1:0]        pwdata,
   output logic [idsa_pkg::DATA_WIDTH-1:0]        prdata,
   output logic                                   pready
);

   localparam int IW  = $clog2(MAX_IDS);
   localparam int AW  = (IW > idsa_pkg::ID_WIDTH) ? IW : idsa_pkg::ID_WIDTH;
   localparam int CAP = (MAX_IDS < 127) ? MAX_IDS : 127;
   localparam int SW  = idsa_pkg::ID_WIDTH;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_RESP  = 3'd3;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [SW-1:0] active_count_ff, active_count_in;
   logic [SW-1:0] ptr_ff, ptr_in;
   logic [SW-1:0] scan_slot_ff, scan_slot_in;
   logic [SW-1:0] remain_ff, remain_in;
   logic          top_ff, top_in;
   logic          chk_v_ff, chk_v_in;
   logic [SW-1:0] chk_slot_ff, chk_slot_in;
   logic [SW-1:0] res_id_ff, res_id_in;
   logic [1:0]    res_st_ff, res_st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_id_ff, rsp_id_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;
   logic          rd_bit_ff;

   logic          map_mem [MAX_IDS];
   logic          wr_en;
   logic          wr_bit;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] rd_addr;
   logic [AW-1:0] rd_ext, rel_ext, chk_ext;

   logic [SW-1:0] eff_n;
   logic [SW-1:0] rel_slot;
   logic [SW-1:0] nf_next;
   logic          req_fire, csr_write, hit, rsp_load;

   assign eff_n     = (active_count_ff > SW'(CAP)) ? SW'(CAP) : active_count_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite && (paddr == idsa_pkg::ADDR_ACTIVE_COUNT);
   assign pready    = 1'b1;
   assign prdata    = (paddr == idsa_pkg::ADDR_ACTIVE_COUNT) ?
                      idsa_pkg::DATA_WIDTH'(active_count_ff) : '0;

   assign rel_slot = req_release_id - SW'(1);
   assign rd_ext   = AW'(scan_slot_ff);
   assign rel_ext  = AW'(rel_slot);
   assign chk_ext  = AW'(chk_slot_ff);
   assign rd_addr  = rd_ext[IW-1:0];
   assign hit      = chk_v_ff && !rd_bit_ff;
   assign nf_next  = ((scan_slot_ff + SW'(1)) >= eff_n) ? '0 : scan_slot_ff + SW'(1);
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_id_ff;
   assign rsp_status     = rsp_st_ff;

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      active_count_in = csr_write ? pwdata[SW-1:0] : active_count_ff;
      ptr_in          = ptr_ff;
      scan_slot_in    = scan_slot_ff;
      remain_in       = remain_ff;
      top_in          = top_ff;
      chk_v_in        = 1'b0;
      chk_slot_in     = chk_slot_ff;
      res_id_in       = res_id_ff;
      res_st_in       = res_st_ff;
      wr_en           = 1'b0;
      wr_bit          = 1'b0;
      wr_addr         = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(MAX_IDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               res_id_in = '0;
               res_st_in = idsa_pkg::STATUS_OK;
               state_in  = ST_RESP;
               unique case (req_cmd)
                  idsa_pkg::CMD_NEXT_FIT: begin
                     state_in     = ST_SCAN;
                     top_in       = 1'b0;
                     remain_in    = eff_n;
                     scan_slot_in = (ptr_ff < eff_n) ? ptr_ff : '0;
                  end
                  idsa_pkg::CMD_TOP: begin
                     state_in     = ST_SCAN;
                     top_in       = 1'b1;
                     remain_in    = eff_n;
                     scan_slot_in = eff_n - SW'(1);
                  end
                  idsa_pkg::CMD_RELEASE: begin
                     if (req_release_id == '0 || req_release_id > eff_n) begin
                        res_st_in = idsa_pkg::STATUS_BAD_ID;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = rel_ext[IW-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               wr_en     = 1'b1;
               wr_bit    = 1'b1;
               wr_addr   = chk_ext[IW-1:0];
               res_id_in = chk_slot_ff + SW'(1);
               res_st_in = idsa_pkg::STATUS_OK;
               if (!top_ff) begin
                  ptr_in = chk_slot_ff;
               end
               state_in = ST_RESP;
            end else if (remain_ff != '0) begin
               chk_v_in     = 1'b1;
               chk_slot_in  = scan_slot_ff;
               remain_in    = remain_ff - SW'(1);
               scan_slot_in = top_ff ? scan_slot_ff - SW'(1) : nf_next;
            end else begin
               res_id_in = '0;
               res_st_in = idsa_pkg::STATUS_FULL;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_id_in    = rsp_load ? res_id_ff : rsp_id_ff;
      rsp_st_in    = rsp_load ? res_st_ff : rsp_st_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         active_count_ff <= idsa_pkg::ACTIVE_COUNT_RESET;
         ptr_ff          <= '0;
         chk_v_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         active_count_ff <= active_count_in;
         ptr_ff          <= ptr_in;
         chk_v_ff        <= chk_v_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_slot_ff <= scan_slot_in;
      remain_ff    <= remain_in;
      top_ff       <= top_in;
      chk_slot_ff  <= chk_slot_in;
      res_id_ff    <= res_id_in;
      res_st_ff    <= res_st_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_st_ff    <= rsp_st_in;
   end

endmodule

// ===== design/idsa_checker.sv =====
// Port-level assertions for the ID slot allocator and their bind.
`timescale 1ns / 1ps
module idsa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [idsa_pkg::ID_WIDTH-1:0]     rsp_granted_id,
   input logic [idsa_pkg::STATUS_WIDTH-1:0] rsp_status
);

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_id) && $stable(rsp_status))
      else $error("result changed while stalled");

   full_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == idsa_pkg::STATUS_FULL |-> rsp_granted_id == '0)
      else $error("id granted with full status");

   id_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted_id != '0 |-> rsp_status == idsa_pkg::STATUS_OK)
      else $error("id granted with error status");

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction taken while busy");

   idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

endmodule

bind id_slot_allocator idsa_checker u_idsa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_granted_id (rsp_granted_id),
   .rsp_status     (rsp_status)
);
